[sv/ialu_pkg.sv]
// ialu_pkg: shared types and constants for the integer ALU.
// Holds the operation codes, the request word layout and the port field widths.
// Depends on nothing; every other file of the block uses it.
package ialu_pkg;

    localparam int FUNC_W    = 5;
    localparam int OPND_W    = 32;
    localparam int SHAMT_W   = 6;
    localparam int RES_W     = 32;
    localparam int S_TDATA_W = 104;   // 3 * OPND_W + SHAMT_W = 102, padded to whole bytes
    localparam int M_TDATA_W = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD   = 5'd0,
        FUNC_SUB   = 5'd1,
        FUNC_MUL   = 5'd2,
        FUNC_NEG   = 5'd3,
        FUNC_NOT   = 5'd4,
        FUNC_AND   = 5'd5,
        FUNC_OR    = 5'd6,
        FUNC_NAND  = 5'd7,
        FUNC_NOR   = 5'd8,
        FUNC_XOR   = 5'd9,
        FUNC_XNOR  = 5'd10,
        FUNC_ANDNY = 5'd11,
        FUNC_ANDYN = 5'd12,
        FUNC_ORNY  = 5'd13,
        FUNC_ORYN  = 5'd14,
        FUNC_MUX   = 5'd15,
        FUNC_SHL   = 5'd16,
        FUNC_SHR   = 5'd17,
        FUNC_ROTL  = 5'd18,
        FUNC_ROTR  = 5'd19
    } alu_func_t;

    typedef struct packed {
        alu_func_t          func;
        logic [OPND_W-1:0]  operand_a;
        logic [OPND_W-1:0]  operand_b;
        logic [OPND_W-1:0]  operand_c;
        logic [SHAMT_W-1:0] shift_amount;
    } alu_req_t;

endpackage

[sv/ialu_exec.sv]
// ialu_exec: combinational datapath of the integer ALU, one operation per word.
// Evaluates the selected operation on WIDTH-bit operands, including the rotators.
// Depends on ialu_pkg.
module ialu_exec #(
    parameter int WIDTH = 32
) (
    input  ialu_pkg::alu_req_t        req,
    output logic [ialu_pkg::RES_W-1:0] result_value
);

    // Bits of a 32-bit port field that survive the reduction to WIDTH
    localparam int OW = (WIDTH < ialu_pkg::OPND_W) ? WIDTH : ialu_pkg::OPND_W;
    localparam int NSTG = ialu_pkg::SHAMT_W;

    logic [WIDTH-1:0]  a_w;
    logic [WIDTH-1:0]  b_w;
    logic [WIDTH-1:0]  c_w;
    logic [2*OW-1:0]   prod;
    logic [WIDTH-1:0]  mul_w;
    logic [WIDTH-1:0]  rl [0:NSTG];
    logic [WIDTH-1:0]  rr [0:NSTG];
    logic [WIDTH-1:0]  r;

    assign a_w = WIDTH'(req.operand_a[OW-1:0]);
    assign b_w = WIDTH'(req.operand_b[OW-1:0]);
    assign c_w = WIDTH'(req.operand_c[OW-1:0]);

    // At most 32 x 32; keep the low WIDTH bits
    assign prod  = (2*OW)'(req.operand_a[OW-1:0]) * (2*OW)'(req.operand_b[OW-1:0]);
    assign mul_w = WIDTH'(prod);

    // Rotators: stage i rotates by 2^i mod WIDTH when amount bit i is set,
    // so the chain rotates by the full amount mod WIDTH.
    assign rl[0] = a_w;
    assign rr[0] = a_w;
    for (genvar i = 0; i < NSTG; i++) begin : g_rot
        localparam int K = (2 ** i) % WIDTH;
        logic [WIDTH-1:0] rl_k;
        logic [WIDTH-1:0] rr_k;
        assign rl_k  = (rl[i] << K) | (rl[i] >> (WIDTH - K));
        assign rr_k  = (rr[i] >> K) | (rr[i] << (WIDTH - K));
        assign rl[i+1] = req.shift_amount[i] ? rl_k : rl[i];
        assign rr[i+1] = req.shift_amount[i] ? rr_k : rr[i];
    end

    always_comb
    begin
        unique case (req.func)
            ialu_pkg::FUNC_ADD:   r = a_w + b_w;
            ialu_pkg::FUNC_SUB:   r = a_w - b_w;
            ialu_pkg::FUNC_MUL:   r = mul_w;
            ialu_pkg::FUNC_NEG:   r = ~a_w + WIDTH'(1);
            ialu_pkg::FUNC_NOT:   r = ~a_w;
            ialu_pkg::FUNC_AND:   r = a_w & b_w;
            ialu_pkg::FUNC_OR:    r = a_w | b_w;
            ialu_pkg::FUNC_NAND:  r = ~(a_w & b_w);
            ialu_pkg::FUNC_NOR:   r = ~(a_w | b_w);
            ialu_pkg::FUNC_XOR:   r = a_w ^ b_w;
            ialu_pkg::FUNC_XNOR:  r = ~(a_w ^ b_w);
            ialu_pkg::FUNC_ANDNY: r = ~a_w & b_w;
            ialu_pkg::FUNC_ANDYN: r = a_w & ~b_w;
            ialu_pkg::FUNC_ORNY:  r = ~a_w | b_w;
            ialu_pkg::FUNC_ORYN:  r = a_w | ~b_w;
            ialu_pkg::FUNC_MUX:   r = (a_w & b_w) | (~a_w & c_w);
            ialu_pkg::FUNC_SHL:   r = a_w << req.shift_amount;   // zero once amount >= WIDTH
            ialu_pkg::FUNC_SHR:   r = a_w >> req.shift_amount;
            ialu_pkg::FUNC_ROTL:  r = rl[NSTG];
            ialu_pkg::FUNC_ROTR:  r = rr[NSTG];
            default:              r = '0;
        endcase
    end

    assign result_value = ialu_pkg::RES_W'(r[OW-1:0]);

endmodule

[sv/integer_alu_unit.sv]
// integer_alu_unit: top level of the WIDTH-bit integer ALU with stream ports.
// Registers the request, runs it through ialu_exec and registers the result.
// Depends on ialu_pkg and ialu_exec.
//
//  channel   | dir | handshake             | payload
//  ----------+-----+-----------------------+-----------------------------------------
//  s_axis    | in  | s_axis_tvalid/tready  | tuser: func; tdata: a, b, c, shift_amount
//  m_axis    | out | m_axis_tvalid/tready  | tdata: result_value
//
// An accepted word sits in the request register while the ALU logic
// (the 32 x 32 multiplier sets the path) evaluates it, then moves to the result
// register. One word per cycle is sustained while m_axis_tready stays high.
// rst_n clears both valid flags asynchronously; payload registers are not reset.
// A stalled result holds in the result register while the request register
// still takes one more word; tready drops only when both stages are full.
module integer_alu_unit #(
    parameter int WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ialu_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [31:0] operand_a, [63:32] operand_b,
                                                            // [95:64] operand_c,
                                                            // [101:96] shift_amount, [103:102] unused
    input  logic [ialu_pkg::FUNC_W-1:0]      s_axis_tuser,  // [4:0] func
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ialu_pkg::M_TDATA_W-1:0]   m_axis_tdata   // [31:0] result_value
);

    localparam int OW = ialu_pkg::OPND_W;

    logic                           req_valid_reg;
    logic                           req_valid_next;
    ialu_pkg::alu_req_t             req_reg;
    ialu_pkg::alu_req_t             req_in;
    logic                           res_valid_reg;
    logic                           res_valid_next;
    logic [ialu_pkg::RES_W-1:0]     res_reg;
    logic [ialu_pkg::RES_W-1:0]     res_calc;
    logic                           s_fire;
    logic                           advance;

    // Unpack the incoming word
    always_comb
    begin
        req_in.func         = ialu_pkg::alu_func_t'(s_axis_tuser);
        req_in.operand_a    = s_axis_tdata[OW-1:0];
        req_in.operand_b    = s_axis_tdata[2*OW-1:OW];
        req_in.operand_c    = s_axis_tdata[3*OW-1:2*OW];
        req_in.shift_amount = s_axis_tdata[3*OW+ialu_pkg::SHAMT_W-1:3*OW];
    end

    // Request moves on when the result register is empty or being drained
    assign advance       = req_valid_reg && (!res_valid_reg || m_axis_tready);
    assign s_axis_tready = !req_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    ialu_exec #(
        .WIDTH (WIDTH)
    ) u_exec (
        .req          (req_reg),
        .result_value (res_calc)
    );

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (s_fire)
            req_valid_next = 1'b1;
        else if (advance)
            req_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = 1'b1;
        else if (m_axis_tready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload: the request loads on acceptance, the result when the request advances; each holds otherwise
    always_ff @(posedge clk)
    begin
        if (s_fire)
            req_reg <= req_in;
        if (advance)
            res_reg <= res_calc;
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = res_reg;

endmodule
